[rtl/connection_tracking_table_top_assert.svh]
`ifndef CONNECTION_TRACKING_TABLE_TOP_ASSERT_SVH
`define CONNECTION_TRACKING_TABLE_TOP_ASSERT_SVH

// checked only out of reset
`define CTT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define CTT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/ctt_pkg.sv]
package ctt_pkg;

    localparam int FLOW_ENTRIES_DEF = 1024;
    localparam int QUEUE_DEPTH_DEF  = 2;

    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;
    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] ICMP_ECHO_REQ = 8'd8;
    localparam logic [7:0] ICMP_ECHO_REP = 8'd0;

    localparam logic [2:0] OUT_IGNORED   = 3'd0;
    localparam logic [2:0] OUT_INSERTED  = 3'd1;
    localparam logic [2:0] OUT_REFRESHED = 3'd2;
    localparam logic [2:0] OUT_FULL      = 3'd3;
    localparam logic [2:0] OUT_HIT       = 3'd4;
    localparam logic [2:0] OUT_MISS      = 3'd5;
    localparam logic [2:0] OUT_EXPIRED   = 3'd6;

    localparam logic [1:0] FS_NONE = 2'd0;
    localparam logic [1:0] FS_NEW  = 2'd1;
    localparam logic [1:0] FS_EST  = 2'd2;

    localparam logic [2:0] CFG_ENABLED   = 3'd0;
    localparam logic [2:0] CFG_TCP_EST   = 3'd1;
    localparam logic [2:0] CFG_TCP_NEW   = 3'd2;
    localparam logic [2:0] CFG_UDP       = 3'd3;
    localparam logic [2:0] CFG_OTHER     = 3'd4;
    localparam logic [2:0] CFG_MAX_AGE   = 3'd5;

    localparam logic [63:0] TCP_EST_RST = 64'd300000000000;
    localparam logic [63:0] TCP_NEW_RST = 64'd30000000000;
    localparam logic [63:0] UDP_RST     = 64'd120000000000;
    localparam logic [63:0] OTHER_RST   = 64'd30000000000;

    typedef enum logic [1:0] {
        KIND_IGNORE,
        KIND_MISS,
        KIND_EGRESS,
        KIND_INGRESS
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [63:0] addrs;
        logic [39:0] ppp;
        logic [7:0]  proto;
        logic        est;
        logic [63:0] now;
    } item_t;

    typedef struct packed {
        logic        valid;
        logic [63:0] addrs;
        logic [39:0] ppp;
        logic [63:0] seen_ns;
        logic [63:0] created;
        logic        est;
    } entry_t;

    typedef struct packed {
        logic        enabled;
        logic [63:0] tcp_est;
        logic [63:0] tcp_new;
        logic [63:0] udp;
        logic [63:0] other;
        logic [63:0] max_age;
    } cfg_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

[rtl/ctt_ram.sv]
module ctt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/ctt_front.sv]
module ctt_front (
    input  logic          enabled,
    input  logic          func,
    input  logic [31:0]   src_addr,
    input  logic [31:0]   dst_addr,
    input  logic [15:0]   src_port,
    input  logic [15:0]   dst_port,
    input  logic [7:0]    protocol,
    input  logic          tcp_ack,
    input  logic [7:0]    icmp_kind,
    input  logic [15:0]   icmp_echo_id,
    input  logic [63:0]   now_ns,
    output ctt_pkg::item_t item
);

    logic [15:0] lport;
    logic [15:0] rport;

    always_comb
    begin
        lport = 16'd0;
        rport = 16'd0;
        item.kind = func ? ctt_pkg::KIND_INGRESS : ctt_pkg::KIND_EGRESS;
        if (protocol == ctt_pkg::PROTO_TCP || protocol == ctt_pkg::PROTO_UDP)
        begin
            lport = func ? dst_port : src_port;
            rport = func ? src_port : dst_port;
        end
        else if (protocol == ctt_pkg::PROTO_ICMP)
        begin
            lport = icmp_echo_id;
            // only echo traffic is tracked
            if (!func && icmp_kind != ctt_pkg::ICMP_ECHO_REQ)
            begin
                item.kind = ctt_pkg::KIND_IGNORE;
            end
            if (func && icmp_kind != ctt_pkg::ICMP_ECHO_REP)
            begin
                item.kind = ctt_pkg::KIND_MISS;
            end
        end
        if (!enabled)
        begin
            item.kind = ctt_pkg::KIND_IGNORE;
        end
        item.addrs = func ? {dst_addr, src_addr} : {src_addr, dst_addr};
        item.ppp   = {lport, rport, protocol};
        item.proto = protocol;
        item.est   = !func && protocol == ctt_pkg::PROTO_TCP && tcp_ack;
        item.now   = now_ns;
    end

endmodule

[rtl/ctt_queue.sv]
module ctt_queue #(
    parameter int DEPTH = ctt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ctt_pkg::item_t push_item,
    input  logic           pop,
    output logic           full,
    output logic           avail,
    output ctt_pkg::item_t head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ctt_pkg::item_t mem_reg [DEPTH];
    logic [PW-1:0] wptr_reg;
    logic [PW-1:0] rptr_reg;
    logic [CW-1:0] cnt_reg;

    assign full  = cnt_reg == CW'(DEPTH);
    assign avail = cnt_reg != '0;
    assign head  = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

[rtl/ctt_back.sv]
module ctt_back #(
    parameter int FLOW_ENTRIES = ctt_pkg::FLOW_ENTRIES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctt_pkg::cfg_t         cfg,
    input  logic                  q_avail,
    input  ctt_pkg::item_t        q_item,
    output logic                  q_pop,
    output ctt_pkg::back_status_t status,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0]            outcome,
    output logic [1:0]            flow_state
);

    localparam int IW = $clog2(FLOW_ENTRIES);
    localparam int EW = $bits(ctt_pkg::entry_t);
    localparam logic [IW:0]   ENTRIES = (IW + 1)'(FLOW_ENTRIES);
    localparam logic [IW-1:0] LAST    = IW'(FLOW_ENTRIES - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_ACT
    } state_t;

    state_t          state_reg, state_next;
    logic [IW:0]     cnt_reg, cnt_next;
    logic            pend_reg, pend_next;
    logic [IW-1:0]   pend_idx_reg, pend_idx_next;
    ctt_pkg::item_t  cur_reg, cur_next;
    logic            hit_reg, hit_next;
    logic [IW-1:0]   slot_reg, slot_next;
    logic            free_found_reg, free_found_next;
    logic [IW-1:0]   free_idx_reg, free_idx_next;
    ctt_pkg::entry_t ent_reg, ent_next;
    logic            out_valid_reg, out_valid_next;
    logic [2:0]      outcome_reg, outcome_next;
    logic [1:0]      fstate_reg, fstate_next;

    logic            we;
    logic [IW-1:0]   waddr;
    ctt_pkg::entry_t wentry;
    logic [IW-1:0]   raddr;
    logic [EW-1:0]   rdata;
    ctt_pkg::entry_t rd;
    logic            out_free;
    logic            issue;
    logic [63:0]     limit;
    logic            expired;

    ctt_ram #(
        .WIDTH (EW),
        .DEPTH (FLOW_ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (EW'(wentry)),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign rd         = ctt_pkg::entry_t'(rdata);
    assign out_free   = !out_valid_reg || !out_stall;
    assign out_valid  = out_valid_reg;
    assign outcome    = outcome_reg;
    assign flow_state = fstate_reg;
    assign status.clearing = state_reg == S_CLEAR;

    // idle and age limits, both compared mod 2^64
    always_comb
    begin
        if (cur_reg.proto == ctt_pkg::PROTO_TCP)
        begin
            limit = ent_reg.est ? cfg.tcp_est : cfg.tcp_new;
        end
        else if (cur_reg.proto == ctt_pkg::PROTO_UDP)
        begin
            limit = cfg.udp;
        end
        else
        begin
            limit = cfg.other;
        end
        expired = (cur_reg.now - ent_reg.seen_ns) >= limit;
        if (cfg.max_age != '0 && ent_reg.created != '0
            && (cur_reg.now - ent_reg.created) >= cfg.max_age)
        begin
            expired = 1'b1;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        cur_next        = cur_reg;
        hit_next        = hit_reg;
        slot_next       = slot_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        ent_next        = ent_reg;
        out_valid_next  = out_valid_reg && out_stall;
        outcome_next    = outcome_reg;
        fstate_next     = fstate_reg;
        we              = 1'b0;
        waddr           = cnt_reg[IW-1:0];
        wentry          = '0;
        raddr           = cnt_reg[IW-1:0];
        q_pop           = 1'b0;
        issue           = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
                if (cnt_reg[IW-1:0] == LAST)
                begin
                    state_next = S_IDLE;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (q_avail)
                begin
                    if (q_item.kind == ctt_pkg::KIND_IGNORE
                        || q_item.kind == ctt_pkg::KIND_MISS)
                    begin
                        if (out_free)
                        begin
                            q_pop          = 1'b1;
                            out_valid_next = 1'b1;
                            outcome_next   = (q_item.kind == ctt_pkg::KIND_IGNORE)
                                           ? ctt_pkg::OUT_IGNORED : ctt_pkg::OUT_MISS;
                            fstate_next    = ctt_pkg::FS_NONE;
                        end
                    end
                    else
                    begin
                        q_pop           = 1'b1;
                        cur_next        = q_item;
                        cnt_next        = '0;
                        pend_next       = 1'b0;
                        hit_next        = 1'b0;
                        free_found_next = 1'b0;
                        state_next      = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // one slot read per cycle, compared in the cycle after its read
                issue         = cnt_reg < ENTRIES;
                pend_next     = issue;
                pend_idx_next = cnt_reg[IW-1:0];
                if (issue)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    if (!rd.valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = pend_idx_reg;
                    end
                    if (rd.valid && rd.addrs == cur_reg.addrs && rd.ppp == cur_reg.ppp)
                    begin
                        hit_next   = 1'b1;
                        slot_next  = pend_idx_reg;
                        ent_next   = rd;
                        pend_next  = 1'b0;
                        state_next = S_ACT;
                    end
                    else if (pend_idx_reg == LAST)
                    begin
                        pend_next  = 1'b0;
                        state_next = S_ACT;
                    end
                end
            end
            S_ACT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    fstate_next    = ctt_pkg::FS_NONE;
                    waddr          = slot_reg;
                    wentry         = ent_reg;
                    if (cur_reg.kind == ctt_pkg::KIND_EGRESS)
                    begin
                        if (hit_reg)
                        begin
                            we               = 1'b1;
                            wentry.seen_ns   = cur_reg.now;
                            wentry.est       = ent_reg.est | cur_reg.est;
                            outcome_next     = ctt_pkg::OUT_REFRESHED;
                            fstate_next      = wentry.est ? ctt_pkg::FS_EST : ctt_pkg::FS_NEW;
                        end
                        else if (free_found_reg)
                        begin
                            we           = 1'b1;
                            waddr        = free_idx_reg;
                            wentry       = {1'b1, cur_reg.addrs, cur_reg.ppp,
                                            cur_reg.now, cur_reg.now, cur_reg.est};
                            outcome_next = ctt_pkg::OUT_INSERTED;
                            fstate_next  = cur_reg.est ? ctt_pkg::FS_EST : ctt_pkg::FS_NEW;
                        end
                        else
                        begin
                            outcome_next = ctt_pkg::OUT_FULL;
                        end
                    end
                    else if (!hit_reg)
                    begin
                        outcome_next = ctt_pkg::OUT_MISS;
                    end
                    else if (!expired)
                    begin
                        we               = 1'b1;
                        wentry.seen_ns   = cur_reg.now;
                        wentry.est       = 1'b1;
                        outcome_next     = ctt_pkg::OUT_HIT;
                        fstate_next      = ctt_pkg::FS_EST;
                    end
                    else
                    begin
                        we           = 1'b1;
                        wentry.valid = 1'b0;
                        outcome_next = ctt_pkg::OUT_EXPIRED;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            cnt_reg        <= '0;
            pend_reg       <= 1'b0;
            pend_idx_reg   <= '0;
            cur_reg        <= '0;
            hit_reg        <= 1'b0;
            slot_reg       <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            ent_reg        <= '0;
            out_valid_reg  <= 1'b0;
            outcome_reg    <= '0;
            fstate_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pend_reg       <= pend_next;
            pend_idx_reg   <= pend_idx_next;
            cur_reg        <= cur_next;
            hit_reg        <= hit_next;
            slot_reg       <= slot_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            ent_reg        <= ent_next;
            out_valid_reg  <= out_valid_next;
            outcome_reg    <= outcome_next;
            fstate_reg     <= fstate_next;
        end
    end

endmodule

[rtl/connection_tracking_table_top.sv]
// channel   direction  beat qualifier        payload
// in        input      in_valid / in_stall   func .. now_ns
// out       output     out_valid / out_stall outcome, flow_state
// cfg       input      cfg_we                cfg_index, cfg_data
//
// an item that needs a lookup is scanned in the back end: the table memory, with one read
// port and one write port, is read one slot per cycle, ending at the first match
// ignored items and non-echo icmp ingress skip the scan
// after reset a clearing pass writes every table slot, in_stall is high meanwhile
// a two-beat queue and the output register let input and output stall independently
module connection_tracking_table_top #(
    parameter int FLOW_ENTRIES = ctt_pkg::FLOW_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [31:0] src_addr,
    input  logic [31:0] dst_addr,
    input  logic [15:0] src_port,
    input  logic [15:0] dst_port,
    input  logic [7:0]  protocol,
    input  logic        tcp_syn,
    input  logic        tcp_ack,
    input  logic [7:0]  icmp_kind,
    input  logic [15:0] icmp_echo_id,
    input  logic [63:0] now_ns,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  outcome,
    output logic [1:0]  flow_state,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    ctt_pkg::cfg_t         cfg_reg;
    ctt_pkg::item_t        front_item;
    ctt_pkg::item_t        q_head;
    ctt_pkg::back_status_t status;
    logic                  q_full;
    logic                  q_avail;
    logic                  q_pop;
    logic                  push;

    // syn alone decides nothing: ack sets the established state
    logic                  syn_unused;
    assign syn_unused = tcp_syn;

    assign in_stall = q_full || status.clearing || syn_unused & 1'b0;
    assign push     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enabled <= 1'b0;
            cfg_reg.tcp_est <= ctt_pkg::TCP_EST_RST;
            cfg_reg.tcp_new <= ctt_pkg::TCP_NEW_RST;
            cfg_reg.udp     <= ctt_pkg::UDP_RST;
            cfg_reg.other   <= ctt_pkg::OTHER_RST;
            cfg_reg.max_age <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ctt_pkg::CFG_ENABLED: cfg_reg.enabled <= cfg_data[0];
                ctt_pkg::CFG_TCP_EST: cfg_reg.tcp_est <= cfg_data;
                ctt_pkg::CFG_TCP_NEW: cfg_reg.tcp_new <= cfg_data;
                ctt_pkg::CFG_UDP:     cfg_reg.udp     <= cfg_data;
                ctt_pkg::CFG_OTHER:   cfg_reg.other   <= cfg_data;
                ctt_pkg::CFG_MAX_AGE: cfg_reg.max_age <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    ctt_front u_front (
        .enabled      (cfg_reg.enabled),
        .func         (func),
        .src_addr     (src_addr),
        .dst_addr     (dst_addr),
        .src_port     (src_port),
        .dst_port     (dst_port),
        .protocol     (protocol),
        .tcp_ack      (tcp_ack),
        .icmp_kind    (icmp_kind),
        .icmp_echo_id (icmp_echo_id),
        .now_ns       (now_ns),
        .item         (front_item)
    );

    ctt_queue #(
        .DEPTH (ctt_pkg::QUEUE_DEPTH_DEF)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (q_pop),
        .full      (q_full),
        .avail     (q_avail),
        .head      (q_head)
    );

    ctt_back #(
        .FLOW_ENTRIES (FLOW_ENTRIES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_avail    (q_avail),
        .q_item     (q_head),
        .q_pop      (q_pop),
        .status     (status),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .outcome    (outcome),
        .flow_state (flow_state)
    );

endmodule

[rtl/ctt_checker.sv]
`include "connection_tracking_table_top_assert.svh"

module ctt_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [2:0] outcome,
    input logic [1:0] flow_state
);

    `CTT_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(outcome) && $stable(flow_state), "stalled result beat changed")
    `CTT_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !out_valid, "result beat during reset")
    `CTT_ASSERT(a_state_live, out_valid && (outcome == ctt_pkg::OUT_INSERTED || outcome == ctt_pkg::OUT_REFRESHED) |-> flow_state == ctt_pkg::FS_NEW || flow_state == ctt_pkg::FS_EST, "recorded flow without state")
    `CTT_ASSERT(a_state_none, out_valid && (outcome == ctt_pkg::OUT_IGNORED || outcome == ctt_pkg::OUT_FULL || outcome == ctt_pkg::OUT_MISS || outcome == ctt_pkg::OUT_EXPIRED) |-> flow_state == ctt_pkg::FS_NONE, "flow state on a non-entry outcome")
    `CTT_ASSERT(a_hit_est, out_valid && outcome == ctt_pkg::OUT_HIT |-> flow_state == ctt_pkg::FS_EST, "live hit not established")

endmodule

bind connection_tracking_table_top ctt_checker u_ctt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .outcome    (outcome),
    .flow_state (flow_state)
);

[bench/tb.sv]
module tb;

    localparam int ENTRIES     = ctt_pkg::FLOW_ENTRIES_DEF;
    localparam int CYCLE_LIMIT = 40000000;
    localparam int FREE_COUNT  = 160;
    // register indexes past the last register
    localparam logic [2:0] CFG_SPARE_A = 3'd6;
    localparam logic [2:0] CFG_SPARE_B = 3'd7;

    typedef struct {
        logic        func;
        logic [31:0] saddr;
        logic [31:0] daddr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [7:0]  proto;
        logic        syn;
        logic        ack;
        logic [7:0]  itype;
        logic [15:0] echo_id;
        logic [63:0] now;
    } pkt_t;

    typedef struct {
        logic [2:0] outcome;
        logic [1:0] fstate;
    } verdict_t;

    logic        clk = 0;
    logic        rst_n;
    logic        in_valid = 0;
    logic        in_stall;
    logic        func = 0;
    logic [31:0] src_addr = 0;
    logic [31:0] dst_addr = 0;
    logic [15:0] src_port = 0;
    logic [15:0] dst_port = 0;
    logic [7:0]  protocol = 0;
    logic        tcp_syn = 0;
    logic        tcp_ack = 0;
    logic [7:0]  icmp_kind = 0;
    logic [15:0] icmp_echo_id = 0;
    logic [63:0] now_ns = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [2:0]  outcome;
    logic [1:0]  flow_state;
    logic        cfg_we = 0;
    logic [2:0]  cfg_index = 0;
    logic [63:0] cfg_data = 0;

    connection_tracking_table_top DUT (.*);

    always #4 clk = ~clk;

    // flow table mirror
    bit          tbl_valid   [ENTRIES];
    logic [63:0] tbl_addrs   [ENTRIES];
    logic [39:0] tbl_key     [ENTRIES];
    logic [63:0] tbl_last    [ENTRIES];
    logic [63:0] tbl_created [ENTRIES];
    bit          tbl_est     [ENTRIES];

    logic        trk_on;
    logic [63:0] lim_tcp_est, lim_tcp_new, lim_udp, lim_other, lim_age;

    verdict_t    pending[$];
    int          errors = 0;
    int          gap_pct = 0;
    int          stall_pct = 0;
    int          hold_left = 0;
    longint      cycles = 0;
    logic [63:0] clock_ns = 0;

    function automatic int find_flow(logic [63:0] a, logic [39:0] k);
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i] && tbl_addrs[i] == a && tbl_key[i] == k)
                return i;
        return -1;
    endfunction

    function automatic verdict_t track_packet(pkt_t p);
        verdict_t    r;
        logic [15:0] lp, rp;
        logic [63:0] a, lim;
        logic [39:0] k;
        int          slot;
        bit          est, expd;
        r.outcome = ctt_pkg::OUT_IGNORED;
        r.fstate = ctt_pkg::FS_NONE;
        if (!trk_on)
            return r;
        if (p.func == 1'b0)
        begin
            est = 0;
            if (p.proto == ctt_pkg::PROTO_TCP)
            begin
                lp = p.sport; rp = p.dport; est = p.ack;
            end
            else if (p.proto == ctt_pkg::PROTO_UDP)
            begin
                lp = p.sport; rp = p.dport;
            end
            else if (p.proto == ctt_pkg::PROTO_ICMP)
            begin
                if (p.itype != ctt_pkg::ICMP_ECHO_REQ)
                    return r;
                lp = p.echo_id; rp = 0;
            end
            else
            begin
                lp = 0; rp = 0;
            end
            a = {p.saddr, p.daddr};
            k = {lp, rp, p.proto};
            slot = find_flow(a, k);
            if (slot >= 0)
            begin
                tbl_last[slot] = p.now;
                if (est)
                    tbl_est[slot] = 1;
                r.outcome = ctt_pkg::OUT_REFRESHED;
                r.fstate = tbl_est[slot] ? ctt_pkg::FS_EST : ctt_pkg::FS_NEW;
                return r;
            end
            for (int i = 0; i < ENTRIES; i++)
                if (!tbl_valid[i])
                begin
                    tbl_valid[i] = 1;
                    tbl_addrs[i] = a;
                    tbl_key[i] = k;
                    tbl_last[i] = p.now;
                    tbl_created[i] = p.now;
                    tbl_est[i] = est;
                    r.outcome = ctt_pkg::OUT_INSERTED;
                    r.fstate = est ? ctt_pkg::FS_EST : ctt_pkg::FS_NEW;
                    return r;
                end
            r.outcome = ctt_pkg::OUT_FULL;
            return r;
        end
        r.outcome = ctt_pkg::OUT_MISS;
        if (p.proto == ctt_pkg::PROTO_TCP || p.proto == ctt_pkg::PROTO_UDP)
        begin
            lp = p.dport; rp = p.sport;
        end
        else if (p.proto == ctt_pkg::PROTO_ICMP)
        begin
            if (p.itype != ctt_pkg::ICMP_ECHO_REP)
                return r;
            lp = p.echo_id; rp = 0;
        end
        else
        begin
            lp = 0; rp = 0;
        end
        slot = find_flow({p.daddr, p.saddr}, {lp, rp, p.proto});
        if (slot < 0)
            return r;
        if (p.proto == ctt_pkg::PROTO_TCP)
            lim = tbl_est[slot] ? lim_tcp_est : lim_tcp_new;
        else if (p.proto == ctt_pkg::PROTO_UDP)
            lim = lim_udp;
        else
            lim = lim_other;
        expd = (p.now - tbl_last[slot]) >= lim;
        if (lim_age != 0 && tbl_created[slot] != 0 && (p.now - tbl_created[slot]) >= lim_age)
            expd = 1;
        if (expd)
        begin
            tbl_valid[slot] = 0;
            r.outcome = ctt_pkg::OUT_EXPIRED;
        end
        else
        begin
            tbl_last[slot] = p.now;
            tbl_est[slot] = 1;
            r.outcome = ctt_pkg::OUT_HIT;
            r.fstate = ctt_pkg::FS_EST;
        end
        return r;
    endfunction

    // called at a falling edge, returns at a falling edge with the beat taken
    task automatic send_packet(pkt_t p, output verdict_t v);
        if (gap_pct > 0 && $urandom_range(99) < gap_pct)
        begin
            in_valid <= 0;
            do
                @(negedge clk);
            while ($urandom_range(99) < gap_pct);
        end
        in_valid <= 1;
        func <= p.func;
        src_addr <= p.saddr;
        dst_addr <= p.daddr;
        src_port <= p.sport;
        dst_port <= p.dport;
        protocol <= p.proto;
        tcp_syn <= p.syn;
        tcp_ack <= p.ack;
        icmp_kind <= p.itype;
        icmp_echo_id <= p.echo_id;
        now_ns <= p.now;
        do
            @(posedge clk);
        while (in_stall);
        v = track_packet(p);
        pending.push_back(v);
        @(negedge clk);
    endtask

    task automatic send(pkt_t p);
        verdict_t v;
        send_packet(p, v);
    endtask

    task automatic wait_drain();
        in_valid <= 0;
        while (pending.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        in_valid <= 0;
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 0;
        case (idx)
            ctt_pkg::CFG_ENABLED: trk_on = val[0];
            ctt_pkg::CFG_TCP_EST: lim_tcp_est = val;
            ctt_pkg::CFG_TCP_NEW: lim_tcp_new = val;
            ctt_pkg::CFG_UDP:     lim_udp = val;
            ctt_pkg::CFG_OTHER:   lim_other = val;
            ctt_pkg::CFG_MAX_AGE: lim_age = val;
            default: ;
        endcase
    endtask

    task automatic set_timeouts(logic [63:0] te, logic [63:0] tn, logic [63:0] u,
                                logic [63:0] o, logic [63:0] age);
        wait_drain();
        write_reg(ctt_pkg::CFG_TCP_EST, te);
        write_reg(ctt_pkg::CFG_TCP_NEW, tn);
        write_reg(ctt_pkg::CFG_UDP, u);
        write_reg(ctt_pkg::CFG_OTHER, o);
        write_reg(ctt_pkg::CFG_MAX_AGE, age);
    endtask

    function automatic pkt_t make_pkt(logic f, logic [31:0] sa, logic [31:0] da,
                                      logic [15:0] sp, logic [15:0] dp, logic [7:0] pr,
                                      logic s, logic ak, logic [7:0] it, logic [15:0] id,
                                      logic [63:0] t);
        pkt_t p;
        p.func = f; p.saddr = sa; p.daddr = da; p.sport = sp; p.dport = dp;
        p.proto = pr; p.syn = s; p.ack = ak; p.itype = it; p.echo_id = id; p.now = t;
        return p;
    endfunction

    // ingress packet that finds the given table entry
    function automatic pkt_t reply_to(int i, logic [63:0] t);
        logic [7:0] pr;
        pr = tbl_key[i][7:0];
        return make_pkt(1, tbl_addrs[i][31:0], tbl_addrs[i][63:32], tbl_key[i][23:8],
                        tbl_key[i][39:24], pr, 0, 1, ctt_pkg::ICMP_ECHO_REP,
                        tbl_key[i][39:24], t);
    endfunction

    // flow pool for the random part
    pkt_t pool[16];

    function automatic pkt_t random_pkt();
        pkt_t p, f;
        int   r;
        r = $urandom_range(99);
        if (r < 12)
        begin
            p = make_pkt(1'($urandom), $urandom, $urandom, 16'($urandom), 16'($urandom),
                         8'($urandom), 1'($urandom), 1'($urandom), 8'($urandom),
                         16'($urandom), {$urandom, $urandom});
            if (r < 9)
                p.now = clock_ns;
            return p;
        end
        f = pool[$urandom_range(15)];
        clock_ns += 64'($urandom_range(400));
        if ($urandom_range(99) < 3)
            clock_ns += 64'($urandom_range(20000));
        p = f;
        p.func = 1'($urandom_range(1));
        p.syn = 1'($urandom);
        p.ack = $urandom_range(99) < 60;
        p.now = clock_ns;
        if (p.func)
        begin
            p.saddr = f.daddr; p.daddr = f.saddr;
            p.sport = f.dport; p.dport = f.sport;
            p.itype = ($urandom_range(9) == 0) ? 8'($urandom) : ctt_pkg::ICMP_ECHO_REP;
        end
        else
        begin
            p.itype = ($urandom_range(9) == 0) ? 8'($urandom) : ctt_pkg::ICMP_ECHO_REQ;
        end
        if (p.proto != ctt_pkg::PROTO_TCP && p.proto != ctt_pkg::PROTO_UDP
            && $urandom_range(1))
        begin
            p.sport = 16'($urandom); p.dport = 16'($urandom);
        end
        return p;
    endfunction

    task automatic test_directed();
        logic [63:0] big;
        big = 64'hFFFF_FFFF_FFFF_FF00;
        // disabled: everything ignored
        send(make_pkt(0, 32'h0A000001, 32'h0A000002, 1000, 80, ctt_pkg::PROTO_TCP,
                      1, 0, 0, 0, 100));
        send(make_pkt(1, 32'hFFFFFFFF, 32'h0, 16'hFFFF, 0, 8'hFF, 1, 1, 8'hFF, 16'hFFFF, '1));
        wait_drain();
        write_reg(ctt_pkg::CFG_ENABLED, 1);
        write_reg(CFG_SPARE_A, '1);
        write_reg(CFG_SPARE_B, 64'h0);
        // tcp syn, then ack promotes, then reply hits
        send(make_pkt(0, 32'h0A000001, 32'h0A000002, 1000, 80, ctt_pkg::PROTO_TCP,
                      1, 0, 0, 0, 100));
        send(make_pkt(0, 32'h0A000001, 32'h0A000002, 1000, 80, ctt_pkg::PROTO_TCP,
                      0, 1, 0, 0, 200));
        send(make_pkt(0, 32'h0A000001, 32'h0A000002, 1000, 80, ctt_pkg::PROTO_TCP,
                      1, 0, 0, 0, 250));
        send(make_pkt(1, 32'h0A000002, 32'h0A000001, 80, 1000, ctt_pkg::PROTO_TCP,
                      1, 1, 0, 0, 300));
        // syn+ack inserts established, unmatched reply misses
        send(make_pkt(0, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, ctt_pkg::PROTO_TCP,
                      1, 1, 0, 0, big));
        send(make_pkt(1, 32'h0A000009, 32'h0A000001, 80, 1000, ctt_pkg::PROTO_TCP,
                      0, 1, 0, 0, 300));
        // udp and the zero key
        send(make_pkt(0, 32'h0, 32'h0, 0, 0, ctt_pkg::PROTO_UDP, 0, 0, 0, 0, 0));
        send(make_pkt(1, 32'h0, 32'h0, 0, 0, ctt_pkg::PROTO_UDP, 0, 0, 0, 0, 5));
        // icmp echo request tracked, other types ignored on egress, missed on ingress
        send(make_pkt(0, 32'hC0A80001, 32'h08080808, 7, 9, ctt_pkg::PROTO_ICMP, 0, 0,
                      ctt_pkg::ICMP_ECHO_REQ, 16'h1234, 400));
        send(make_pkt(0, 32'hC0A80001, 32'h08080808, 7, 9, ctt_pkg::PROTO_ICMP, 0, 0,
                      8'd3, 1, 400));
        send(make_pkt(1, 32'h08080808, 32'hC0A80001, 1, 2, ctt_pkg::PROTO_ICMP, 0, 0, 8'd5,
                      16'h1234, 410));
        send(make_pkt(1, 32'h08080808, 32'hC0A80001, 1, 2, ctt_pkg::PROTO_ICMP, 0, 0,
                      ctt_pkg::ICMP_ECHO_REP, 16'h1234, 420));
        // other protocol: ports carry no meaning
        send(make_pkt(0, 32'h01020304, 32'h05060708, 11, 22, 8'd47, 0, 0, 0, 0, 500));
        send(make_pkt(1, 32'h05060708, 32'h01020304, 33, 44, 8'd47, 0, 0, 0, 0, 510));
        // idle expiry: udp flow seen long after
        send(make_pkt(0, 32'h0B000001, 32'h0B000002, 53, 53, ctt_pkg::PROTO_UDP,
                      0, 0, 0, 0, 1000));
        send(make_pkt(1, 32'h0B000002, 32'h0B000001, 53, 53, ctt_pkg::PROTO_UDP, 0, 0, 0, 0,
                      1000 + ctt_pkg::UDP_RST));
        // wrap of the time difference: established tcp entry at big, now slightly later
        send(make_pkt(1, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, ctt_pkg::PROTO_TCP,
                      0, 1, 0, 0, 64'h40));
        // max age, and created at zero skips it
        set_timeouts('1, '1, '1, '1, 64'd50);
        send(make_pkt(0, 32'h0C000001, 32'h0C000002, 5, 6, ctt_pkg::PROTO_UDP,
                      0, 0, 0, 0, 2000));
        send(make_pkt(1, 32'h0C000002, 32'h0C000001, 6, 5, ctt_pkg::PROTO_UDP,
                      0, 0, 0, 0, 2049));
        send(make_pkt(1, 32'h0C000002, 32'h0C000001, 6, 5, ctt_pkg::PROTO_UDP,
                      0, 0, 0, 0, 2050));
        send(make_pkt(1, 32'h0, 32'h0, 0, 0, ctt_pkg::PROTO_UDP, 0, 0, 0, 0, 64'h1000));
        wait_drain();
        // zero limits expire everything
        set_timeouts(0, 0, 0, 0, 0);
        send(make_pkt(1, 32'h0A000002, 32'h0A000001, 80, 1000, ctt_pkg::PROTO_TCP,
                      0, 0, 0, 0, 300));
        wait_drain();
    endtask

    task automatic test_table_full();
        verdict_t v;
        int       n;
        int       freed;
        set_timeouts(ctt_pkg::TCP_EST_RST, ctt_pkg::TCP_NEW_RST, ctt_pkg::UDP_RST,
                     ctt_pkg::OTHER_RST, 0);
        n = 0;
        do
        begin
            send_packet(make_pkt(0, 32'h0D000000 + n, 32'h0E000000, 16'(n), 443,
                                 ctt_pkg::PROTO_UDP, 0, 0, 0, 0, 5000 + n), v);
            n++;
        end
        while (v.outcome != ctt_pkg::OUT_FULL);
        send(make_pkt(0, 32'h0D000000, 32'h0E000000, 0, 443, ctt_pkg::PROTO_UDP,
                      0, 0, 0, 0, 9000));
        // free the low slots again for the random part
        set_timeouts(0, 0, 0, 0, 0);
        freed = 0;
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i] && freed < FREE_COUNT)
            begin
                send(reply_to(i, 64'd10000));
                freed++;
            end
        wait_drain();
    endtask

    task automatic test_random(int n, int gp, int sp);
        set_timeouts(64'($urandom_range(1500, 5000)), 64'($urandom_range(300, 1500)),
                     64'($urandom_range(800, 3000)), 64'($urandom_range(300, 1200)),
                     $urandom_range(1) ? 64'd0 : 64'($urandom_range(4000, 12000)));
        gap_pct = gp;
        stall_pct = sp;
        repeat (n)
            send(random_pkt());
        wait_drain();
        gap_pct = 0;
        stall_pct = 0;
    endtask

    task automatic test_backpressure();
        set_timeouts(5000, 1000, 3000, 1000, 0);
        hold_left = 3000;
        repeat (40)
            send(random_pkt());
        wait_drain();
        repeat (10)
            send(random_pkt());
        wait_drain();
    endtask

    task automatic test_disable_toggle();
        write_reg(ctt_pkg::CFG_ENABLED, 0);
        repeat (20)
            send(random_pkt());
        wait_drain();
        write_reg(ctt_pkg::CFG_ENABLED, 1);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        trk_on = 0;
        lim_tcp_est = ctt_pkg::TCP_EST_RST;
        lim_tcp_new = ctt_pkg::TCP_NEW_RST;
        lim_udp = ctt_pkg::UDP_RST;
        lim_other = ctt_pkg::OTHER_RST;
        lim_age = 0;
        foreach (tbl_valid[i])
            tbl_valid[i] = 0;
        foreach (pool[i])
        begin
            pool[i] = make_pkt(0, $urandom, $urandom, 16'($urandom), 16'($urandom),
                               ctt_pkg::PROTO_TCP, 0, 0, 0, 16'($urandom), 0);
            case (i % 4)
                1: pool[i].proto = ctt_pkg::PROTO_UDP;
                2: pool[i].proto = ctt_pkg::PROTO_ICMP;
                3: pool[i].proto = 8'd132;
                default: ;
            endcase
        end
        repeat (5)
            @(negedge clk);
        rst_n <= 1;
        @(negedge clk);
        test_directed();
        test_table_full();
        test_random(50, 0, 0);
        test_backpressure();
        test_random(50, 88, 0);
        test_disable_toggle();
        test_random(50, 0, 88);
        test_random(50, 24, 24);
        wait_drain();
        repeat (ENTRIES + 20)
            @(negedge clk);
        if (errors == 0 && pending.size() == 0)
            $display("** connection_tracking_table_top: PASSED **");
        else
            $display("** connection_tracking_table_top: FAILED **");
        $finish;
    end

    // receiver side: long hold-off or random stalling
    always @(negedge clk)
    begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
        out_stall <= (hold_left > 1) || (stall_pct > 0 && $urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        verdict_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected beat: outcome %0d flow_state %0d", outcome,
                             flow_state);
            end
            else
            begin
                e = pending.pop_front();
                if (e.outcome !== outcome || e.fstate !== flow_state)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected outcome %0d flow_state %0d, got %0d %0d",
                                 e.outcome, e.fstate, outcome, flow_state);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** connection_tracking_table_top: FAILED **");
            $finish;
        end
    end

endmodule

[sim.f]
+incdir+rtl
rtl/ctt_pkg.sv
rtl/ctt_ram.sv
rtl/ctt_front.sv
rtl/ctt_queue.sv
rtl/ctt_back.sv
rtl/connection_tracking_table_top.sv
rtl/ctt_checker.sv
bench/tb.sv
